/* hdl/wav_pkg.sv */
// shared types and constants of the wav pcm16 stream parser
`default_nettype none
package wav_pkg;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_RIFF  = 4'd1,
      PH_RSIZE = 4'd2,
      PH_WAVE  = 4'd3,
      PH_CID   = 4'd4,
      PH_CSIZE = 4'd5,
      PH_FMT   = 4'd6,
      PH_SKIP  = 4'd7,
      PH_DATA  = 4'd8,
      PH_DONE  = 4'd9
   } phase_type;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [31:0] FMT_BODY     = 32'd16;
   localparam logic [3:0]  FMT_LAST_IDX = 4'd15;
   localparam logic [3:0]  FMT_CODE_IDX = 4'd1;
   localparam logic [3:0]  FMT_CHAN_IDX = 4'd3;
   localparam logic [2:0]  TAG_LAST_IDX = 3'd3;

   localparam logic [15:0] FORMAT_PCM   = 16'd1;
   localparam logic [15:0] BITS_PCM16   = 16'd16;
   localparam logic [15:0] CHAN_MONO    = 16'd1;
   localparam logic [15:0] CHAN_STEREO  = 16'd2;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_EMPTY  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_NOT_RIFF = 3'd0;
   localparam logic [2:0] ERR_NOT_WAVE = 3'd1;
   localparam logic [2:0] ERR_FORMAT   = 3'd2;
   localparam logic [2:0] ERR_CHANNELS = 3'd3;
   localparam logic [2:0] ERR_NO_DATA  = 3'd4;
   localparam logic [2:0] ERR_TRUNC    = 3'd5;

endpackage
`default_nettype wire

/* hdl/wav_pcm16_stream_parser_top.sv */
// byte-serial riff/wav pcm16 parser with a registered result beat
//
// Takes one byte of a RIFF/WAV file per beat, with start_of_file on the first
// byte and end_of_file on the last, and returns at most one result beat per
// byte: a mono sample (stereo frames averaged, truncated toward zero), an
// empty data chunk notice, or an error code. A byte is taken every cycle unless
// req_stall is high; the result sits in one output register, so req_stall is
// high only while that register holds a beat that rsp_stall keeps from leaving.
// The result of a byte appears in the cycle after the byte is taken. Bytes
// outside a file, or after an error, an empty notice or the final sample, give no
// result until the next start_of_file.
`default_nettype none
module wav_pcm16_stream_parser_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_start_of_file,
   input  wire                req_end_of_file,
   input  wire  [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_sample,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_last_frame
);

   wav_pkg::phase_type phase_ff, phase_in, ph_cur, ph_mid;
   logic [3:0]  cnt_ff, cnt_in, cnt_cur;
   logic [31:0] tag_ff, tag_in, tag_cur;
   logic [31:0] len_ff, len_in, len_cur;
   logic [15:0] chan_ff, chan_in, chan_cur;
   logic [15:0] bits_ff, bits_in, bits_cur;
   logic [15:0] fmt_ff, fmt_in, fmt_cur;
   logic [31:0] frames_ff, frames_in, frames_cur;
   logic [15:0] first_ff, first_in, first_cur;
   logic [7:0]  low_ff, low_in, low_cur;
   logic        pad_ff, pad_in, pad_cur;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] sample_ff, sample_in;
   logic [2:0]  err_ff, err_in;
   logic        last_ff, last_in;

   logic        accept;
   logic        res_valid;
   logic [1:0]  res_kind;
   logic [2:0]  res_err;
   logic [15:0] res_sample;
   logic        res_last;

   logic [15:0] word;
   logic [16:0] pair_sum;
   logic [16:0] pair_adj;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // state seen by this byte: a start of file clears everything
   always_comb begin
      if (req_start_of_file) begin
         ph_cur     = wav_pkg::PH_RIFF;
         cnt_cur    = '0;
         tag_cur    = '0;
         len_cur    = '0;
         chan_cur   = wav_pkg::CHAN_MONO;
         bits_cur   = wav_pkg::BITS_PCM16;
         fmt_cur    = wav_pkg::FORMAT_PCM;
         frames_cur = '0;
         first_cur  = '0;
         low_cur    = '0;
         pad_cur    = 1'b0;
      end else begin
         ph_cur     = phase_ff;
         cnt_cur    = cnt_ff;
         tag_cur    = tag_ff;
         len_cur    = len_ff;
         chan_cur   = chan_ff;
         bits_cur   = bits_ff;
         fmt_cur    = fmt_ff;
         frames_cur = frames_ff;
         first_cur  = first_ff;
         low_cur    = low_ff;
         pad_cur    = pad_ff;
      end
   end

   assign word     = {req_data_byte, low_cur};
   assign pair_sum = {first_cur[15], first_cur} + {word[15], word};
   assign pair_adj = pair_sum + {16'd0, pair_sum[16]};

   // next state
   always_comb begin
      ph_mid     = ph_cur;
      cnt_in     = cnt_cur;
      tag_in     = tag_cur;
      len_in     = len_cur;
      chan_in    = chan_cur;
      bits_in    = bits_cur;
      fmt_in     = fmt_cur;
      frames_in  = frames_cur;
      first_in   = first_cur;
      low_in     = low_cur;
      pad_in     = pad_cur;
      res_valid  = 1'b0;
      res_kind   = wav_pkg::KIND_SAMPLE;
      res_err    = wav_pkg::ERR_NOT_RIFF;
      res_sample = '0;
      res_last   = 1'b0;

      case (ph_cur)
         wav_pkg::PH_RIFF, wav_pkg::PH_WAVE, wav_pkg::PH_CID: begin
            tag_in = {tag_cur[23:0], req_data_byte};
            if (cnt_cur[2:0] != wav_pkg::TAG_LAST_IDX) begin
               cnt_in = cnt_cur + 4'd1;
            end else begin
               cnt_in = '0;
               if (ph_cur == wav_pkg::PH_RIFF) begin
                  if (tag_in != wav_pkg::TAG_RIFF) begin
                     res_valid = 1'b1;
                     res_kind  = wav_pkg::KIND_ERROR;
                     res_err   = wav_pkg::ERR_NOT_RIFF;
                     ph_mid    = wav_pkg::PH_DONE;
                  end else begin
                     ph_mid = wav_pkg::PH_RSIZE;
                  end
               end else if (ph_cur == wav_pkg::PH_WAVE) begin
                  if (tag_in != wav_pkg::TAG_WAVE) begin
                     res_valid = 1'b1;
                     res_kind  = wav_pkg::KIND_ERROR;
                     res_err   = wav_pkg::ERR_NOT_WAVE;
                     ph_mid    = wav_pkg::PH_DONE;
                  end else begin
                     ph_mid = wav_pkg::PH_CID;
                  end
               end else begin
                  ph_mid = wav_pkg::PH_CSIZE;
               end
            end
         end
         wav_pkg::PH_RSIZE: begin
            if (cnt_cur[2:0] != wav_pkg::TAG_LAST_IDX) begin
               cnt_in = cnt_cur + 4'd1;
            end else begin
               cnt_in = '0;
               ph_mid = wav_pkg::PH_WAVE;
            end
         end
         wav_pkg::PH_CSIZE: begin
            len_in = {req_data_byte, len_cur[31:8]};
            if (cnt_cur[2:0] != wav_pkg::TAG_LAST_IDX) begin
               cnt_in = cnt_cur + 4'd1;
            end else begin
               cnt_in = '0;
               if (tag_cur == wav_pkg::TAG_FMT) begin
                  ph_mid = wav_pkg::PH_FMT;
               end else if (tag_cur == wav_pkg::TAG_DATA) begin
                  if (chan_cur == 16'd0 || chan_cur > wav_pkg::CHAN_STEREO) begin
                     res_valid = 1'b1;
                     res_kind  = wav_pkg::KIND_ERROR;
                     res_err   = wav_pkg::ERR_CHANNELS;
                     ph_mid    = wav_pkg::PH_DONE;
                  end else begin
                     // bytes per frame is two or four
                     if (chan_cur == wav_pkg::CHAN_MONO) begin
                        frames_in = {1'b0, len_in[31:1]};
                     end else begin
                        frames_in = {2'b00, len_in[31:2]};
                     end
                     if (frames_in == 32'd0) begin
                        res_valid = 1'b1;
                        res_kind  = wav_pkg::KIND_EMPTY;
                        ph_mid    = wav_pkg::PH_DONE;
                     end else begin
                        ph_mid = wav_pkg::PH_DATA;
                     end
                  end
               end else begin
                  pad_in = len_in[0];
                  if (len_in == 32'd0) begin
                     ph_mid = wav_pkg::PH_CID;
                  end else begin
                     ph_mid = wav_pkg::PH_SKIP;
                  end
               end
            end
         end
         wav_pkg::PH_FMT: begin
            if (!cnt_cur[0]) begin
               low_in = req_data_byte;
            end else if (cnt_cur == wav_pkg::FMT_CODE_IDX) begin
               fmt_in = word;
            end else if (cnt_cur == wav_pkg::FMT_CHAN_IDX) begin
               chan_in = word;
            end else if (cnt_cur == wav_pkg::FMT_LAST_IDX) begin
               bits_in = word;
            end
            if (cnt_cur != wav_pkg::FMT_LAST_IDX) begin
               cnt_in = cnt_cur + 4'd1;
            end else begin
               cnt_in = '0;
               if (fmt_in != wav_pkg::FORMAT_PCM || bits_in != wav_pkg::BITS_PCM16) begin
                  res_valid = 1'b1;
                  res_kind  = wav_pkg::KIND_ERROR;
                  res_err   = wav_pkg::ERR_FORMAT;
                  ph_mid    = wav_pkg::PH_DONE;
               end else if (len_cur > wav_pkg::FMT_BODY) begin
                  pad_in = len_cur[0];
                  len_in = len_cur - wav_pkg::FMT_BODY;
                  ph_mid = wav_pkg::PH_SKIP;
               end else begin
                  ph_mid = wav_pkg::PH_CID;
               end
            end
         end
         wav_pkg::PH_SKIP: begin
            if (len_cur != 32'd0) begin
               len_in = len_cur - 32'd1;
            end else begin
               pad_in = 1'b0;
            end
            if (len_in == 32'd0 && !pad_in) begin
               ph_mid = wav_pkg::PH_CID;
               cnt_in = '0;
            end
         end
         wav_pkg::PH_DATA: begin
            if (!cnt_cur[0]) begin
               low_in = req_data_byte;
               cnt_in = cnt_cur + 4'd1;
            end else if (cnt_cur == 4'd1 && chan_cur != wav_pkg::CHAN_MONO) begin
               first_in = word;
               cnt_in   = 4'd2;
            end else begin
               if (cnt_cur == 4'd1) begin
                  first_in   = word;
                  res_sample = word;
               end else begin
                  res_sample = pair_adj[16:1];
               end
               frames_in = frames_cur - 32'd1;
               res_valid = 1'b1;
               res_kind  = wav_pkg::KIND_SAMPLE;
               res_last  = (frames_in == 32'd0);
               cnt_in    = '0;
               if (res_last) begin
                  ph_mid = wav_pkg::PH_DONE;
               end
            end
         end
         default: begin
         end
      endcase

      phase_in = ph_mid;
      // early end replaces any non-final sample of this byte
      if (req_end_of_file && ph_cur != wav_pkg::PH_IDLE && ph_cur != wav_pkg::PH_DONE
          && ph_mid != wav_pkg::PH_DONE) begin
         res_valid = 1'b1;
         res_kind  = wav_pkg::KIND_ERROR;
         res_last  = 1'b0;
         if (ph_mid inside {wav_pkg::PH_RIFF, wav_pkg::PH_RSIZE, wav_pkg::PH_WAVE,
                            wav_pkg::PH_FMT, wav_pkg::PH_DATA}) begin
            res_err = wav_pkg::ERR_TRUNC;
         end else begin
            res_err = wav_pkg::ERR_NO_DATA;
         end
         phase_in = wav_pkg::PH_DONE;
      end
   end

   // result beat fields
   always_comb begin
      rsp_valid_in = accept ? res_valid : (rsp_valid_ff & rsp_stall);
      kind_in      = res_kind;
      sample_in    = (res_kind == wav_pkg::KIND_SAMPLE) ? res_sample : 16'd0;
      err_in       = (res_kind == wav_pkg::KIND_ERROR) ? res_err : 3'd0;
      last_in      = (res_kind == wav_pkg::KIND_SAMPLE) ? res_last : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wav_pkg::PH_IDLE;
         cnt_ff       <= '0;
         tag_ff       <= '0;
         len_ff       <= '0;
         chan_ff      <= wav_pkg::CHAN_MONO;
         bits_ff      <= wav_pkg::BITS_PCM16;
         fmt_ff       <= wav_pkg::FORMAT_PCM;
         frames_ff    <= '0;
         first_ff     <= '0;
         low_ff       <= '0;
         pad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            cnt_ff    <= cnt_in;
            tag_ff    <= tag_in;
            len_ff    <= len_in;
            chan_ff   <= chan_in;
            bits_ff   <= bits_in;
            fmt_ff    <= fmt_in;
            frames_ff <= frames_in;
            first_ff  <= first_in;
            low_ff    <= low_in;
            pad_ff    <= pad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         kind_ff   <= kind_in;
         sample_ff <= sample_in;
         err_ff    <= err_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_sample     = sample_ff;
   assign rsp_error_code = err_ff;
   assign rsp_last_frame = last_ff;

endmodule
`default_nettype wire

/* tb/wav_pcm16_stream_parser_top_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench of the wav pcm16 stream parser: byte table, then random wav files
module wav_pcm16_stream_parser_top_tb;

   localparam int ITEM_TARGET  = 700;
   localparam int IDLE_LIMIT   = 5000;
   localparam int LONG_HOLD    = 120;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] sample;
      logic [2:0]         err;
      logic               last;
   } beat_type;

   typedef struct packed {
      logic       sof;
      logic       eof;
      logic [7:0] data;
      logic       typed;
      logic       has;
      beat_type   beat;
   } byte_row_type;

   localparam beat_type NO_BEAT = '0;
   localparam beat_type TRUNC_BEAT =
      '{wav_pkg::KIND_ERROR, 16'sh0000, wav_pkg::ERR_TRUNC, 1'b0};
   localparam beat_type LOWEST_LAST_BEAT =
      '{wav_pkg::KIND_SAMPLE, 16'sh8000, 3'd0, 1'b1};

   // stray byte, one-byte truncated file, then a mono file without fmt chunk carrying a single sample
   localparam byte_row_type DIRECTED_BYTES [25] = '{
      '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b0, NO_BEAT},
      '{1'b1, 1'b1, 8'h00, 1'b1, 1'b1, TRUNC_BEAT},
      '{1'b1, 1'b0, "R",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "I",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "F",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "F",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "W",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "A",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "V",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "E",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "d",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "a",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "t",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, "a",   1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'h02, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NO_BEAT},
      '{1'b0, 1'b0, 8'h80, 1'b1, 1'b1, LOWEST_LAST_BEAT},
      '{1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, NO_BEAT}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_start_of_file = 1'b0;
   logic               req_end_of_file = 1'b0;
   logic [7:0]         req_data_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [15:0] rsp_sample;
   logic [2:0]         rsp_error_code;
   logic               rsp_last_frame;

   logic     row_typed = 1'b0;
   logic     row_has = 1'b0;
   beat_type row_beat = NO_BEAT;

   beat_type   expected_beats[$];
   logic [7:0] file_bytes[$];
   int         mismatch_count = 0;
   int         burst_left = 0;
   int         file_items = 0;

   // parser image
   wav_pkg::phase_type ph;
   logic [31:0] step_cnt;
   logic [31:0] tag_window;
   logic [31:0] chunk_left;
   logic [15:0] chan_count;
   logic [15:0] bits_per_sample;
   logic [15:0] format_tag;
   logic [31:0] frames_to_go;
   logic [15:0] left_sample;
   logic [7:0]  low_octet;
   logic        pad_owed;

   wav_pcm16_stream_parser_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_of_file (req_start_of_file),
      .req_end_of_file   (req_end_of_file),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_sample        (rsp_sample),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_frame    (rsp_last_frame)
   );

   always #1 clock = ~clock;

   function automatic void clear_parser();
      ph = wav_pkg::PH_IDLE;
      step_cnt = 0;
      tag_window = 0;
      chunk_left = 0;
      chan_count = wav_pkg::CHAN_MONO;
      bits_per_sample = wav_pkg::BITS_PCM16;
      format_tag = wav_pkg::FORMAT_PCM;
      frames_to_go = 0;
      left_sample = 0;
      low_octet = 0;
      pad_owed = 1'b0;
   endfunction

   function automatic beat_type error_beat(input logic [2:0] code);
      beat_type b = NO_BEAT;
      b.kind = wav_pkg::KIND_ERROR;
      b.err = code;
      ph = wav_pkg::PH_DONE;
      return b;
   endfunction

   function automatic beat_type sample_beat(input logic [15:0] value);
      beat_type b = NO_BEAT;
      frames_to_go--;
      b.kind = wav_pkg::KIND_SAMPLE;
      b.sample = value;
      b.last = (frames_to_go == 0);
      step_cnt = 0;
      if (frames_to_go == 0) ph = wav_pkg::PH_DONE;
      return b;
   endfunction

   function automatic logic parse_byte(input logic sof, input logic eof, input logic [7:0] octet,
                                       output beat_type beat);
      logic        has;
      logic [15:0] word;
      int          total;
      has = 1'b0;
      beat = NO_BEAT;
      if (sof) begin
         clear_parser();
         ph = wav_pkg::PH_RIFF;
      end
      if (ph == wav_pkg::PH_IDLE || ph == wav_pkg::PH_DONE) return 1'b0;
      word = {octet, low_octet};
      case (ph)
         wav_pkg::PH_RIFF, wav_pkg::PH_WAVE, wav_pkg::PH_CID: begin
            tag_window = {tag_window[23:0], octet};
            step_cnt++;
            if (step_cnt == 4) begin
               step_cnt = 0;
               if (ph == wav_pkg::PH_RIFF) begin
                  if (tag_window != wav_pkg::TAG_RIFF) begin
                     beat = error_beat(wav_pkg::ERR_NOT_RIFF);
                     has = 1'b1;
                  end else ph = wav_pkg::PH_RSIZE;
               end else if (ph == wav_pkg::PH_WAVE) begin
                  if (tag_window != wav_pkg::TAG_WAVE) begin
                     beat = error_beat(wav_pkg::ERR_NOT_WAVE);
                     has = 1'b1;
                  end else ph = wav_pkg::PH_CID;
               end else ph = wav_pkg::PH_CSIZE;
            end
         end
         wav_pkg::PH_RSIZE: begin
            step_cnt++;
            if (step_cnt == 4) begin
               step_cnt = 0;
               ph = wav_pkg::PH_WAVE;
            end
         end
         wav_pkg::PH_CSIZE: begin
            chunk_left = {octet, chunk_left[31:8]};
            step_cnt++;
            if (step_cnt == 4) begin
               step_cnt = 0;
               if (tag_window == wav_pkg::TAG_FMT) begin
                  ph = wav_pkg::PH_FMT;
               end else if (tag_window == wav_pkg::TAG_DATA) begin
                  if (chan_count == 0 || chan_count > wav_pkg::CHAN_STEREO) begin
                     beat = error_beat(wav_pkg::ERR_CHANNELS);
                     has = 1'b1;
                  end else begin
                     frames_to_go = chunk_left / (32'(chan_count) * 2);
                     if (frames_to_go == 0) begin
                        beat.kind = wav_pkg::KIND_EMPTY;
                        ph = wav_pkg::PH_DONE;
                        has = 1'b1;
                     end else ph = wav_pkg::PH_DATA;
                  end
               end else begin
                  pad_owed = chunk_left[0];
                  if (chunk_left == 0) ph = wav_pkg::PH_CID;
                  else ph = wav_pkg::PH_SKIP;
               end
            end
         end
         wav_pkg::PH_FMT: begin
            if (!step_cnt[0]) low_octet = octet;
            else if (step_cnt == wav_pkg::FMT_CODE_IDX) format_tag = word;
            else if (step_cnt == wav_pkg::FMT_CHAN_IDX) chan_count = word;
            else if (step_cnt == wav_pkg::FMT_LAST_IDX) bits_per_sample = word;
            step_cnt++;
            if (step_cnt == wav_pkg::FMT_BODY) begin
               if (format_tag != wav_pkg::FORMAT_PCM
                   || bits_per_sample != wav_pkg::BITS_PCM16) begin
                  beat = error_beat(wav_pkg::ERR_FORMAT);
                  has = 1'b1;
               end else if (chunk_left > wav_pkg::FMT_BODY) begin
                  pad_owed = chunk_left[0];
                  chunk_left -= wav_pkg::FMT_BODY;
                  ph = wav_pkg::PH_SKIP;
                  step_cnt = 0;
               end else begin
                  ph = wav_pkg::PH_CID;
                  step_cnt = 0;
               end
            end
         end
         wav_pkg::PH_SKIP: begin
            if (chunk_left != 0) chunk_left--;
            else pad_owed = 1'b0;
            if (chunk_left == 0 && !pad_owed) begin
               ph = wav_pkg::PH_CID;
               step_cnt = 0;
            end
         end
         wav_pkg::PH_DATA: begin
            if (step_cnt == 0 || step_cnt == 2) begin
               low_octet = octet;
               step_cnt++;
            end else if (step_cnt == 1) begin
               left_sample = word;
               if (chan_count == wav_pkg::CHAN_MONO) begin
                  beat = sample_beat(word);
                  has = 1'b1;
               end else step_cnt = 2;
            end else begin
               total = int'($signed(left_sample)) + int'($signed(word));
               beat = sample_beat(16'(total / 2));
               has = 1'b1;
            end
         end
         default: ;
      endcase
      if (eof && ph != wav_pkg::PH_DONE) begin
         if (ph inside {wav_pkg::PH_RIFF, wav_pkg::PH_RSIZE, wav_pkg::PH_WAVE,
                        wav_pkg::PH_FMT, wav_pkg::PH_DATA})
            beat = error_beat(wav_pkg::ERR_TRUNC);
         else
            beat = error_beat(wav_pkg::ERR_NO_DATA);
         has = 1'b1;
      end
      return has;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : result_check
      beat_type predicted;
      beat_type want;
      logic     produces;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat, kind", int'(rsp_kind), -1);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", int'(rsp_kind), int'(want.kind));
               if (rsp_sample !== want.sample)
                  report_mismatch("sample", int'(rsp_sample), int'(want.sample));
               if (rsp_error_code !== want.err)
                  report_mismatch("error_code", int'(rsp_error_code), int'(want.err));
               if (rsp_last_frame !== want.last)
                  report_mismatch("last_frame", int'(rsp_last_frame), int'(want.last));
            end
         end
         if (req_valid && !req_stall) begin
            produces = parse_byte(req_start_of_file, req_end_of_file, req_data_byte, predicted);
            if (row_typed) begin
               produces = row_has;
               predicted = row_beat;
            end
            if (produces) expected_beats.push_back(predicted);
         end
      end
   end

   // starts and ends on a falling edge
   task automatic send_byte(input logic sof, input logic eof, input logic [7:0] octet,
                            input logic typed, input logic has, input beat_type beat);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
         else burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_start_of_file <= sof;
      req_end_of_file <= eof;
      req_data_byte <= octet;
      row_typed <= typed;
      row_has <= has;
      row_beat <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic push_le(input logic [31:0] value, input int count);
      for (int i = 0; i < count; i++) file_bytes.push_back(value[i*8 +: 8]);
   endtask

   task automatic push_tag(input logic [31:0] tag, input int corrupt_pct);
      logic [31:0] t;
      int          lane;
      t = tag;
      if ($urandom_range(0, 99) < corrupt_pct) begin
         lane = $urandom_range(0, 3);
         t[lane*8 +: 8] ^= 8'($urandom_range(1, 255));
      end
      for (int i = 3; i >= 0; i--) file_bytes.push_back(t[i*8 +: 8]);
   endtask

   task automatic push_junk_chunk();
      int len;
      len = $urandom_range(0, 5);
      push_le($urandom, 4);
      push_le(32'(len), 4);
      repeat (len + len % 2) file_bytes.push_back(8'($urandom));
   endtask

   task automatic build_file();
      int          fmt_len;
      int          body;
      int          cut;
      logic [31:0] data_len;
      logic [15:0] chans;
      logic [7:0]  octet;
      file_bytes.delete();
      push_tag(wav_pkg::TAG_RIFF, 4);
      push_le($urandom, 4);
      push_tag(wav_pkg::TAG_WAVE, 4);
      if ($urandom_range(0, 3) == 0) push_junk_chunk();
      if ($urandom_range(0, 9) != 0) begin
         push_tag(wav_pkg::TAG_FMT, 0);
         case ($urandom_range(0, 9))
            0: fmt_len = $urandom_range(0, 15);
            1, 2, 3: fmt_len = $urandom_range(17, 23);
            default: fmt_len = wav_pkg::FMT_BODY;
         endcase
         case ($urandom_range(0, 19))
            0: chans = 16'd0;
            1: chans = 16'($urandom_range(3, 65535));
            default: chans = 16'($urandom_range(1, 2));
         endcase
         push_le(32'(fmt_len), 4);
         push_le(($urandom_range(0, 19) == 0) ? $urandom : 32'(wav_pkg::FORMAT_PCM), 2);
         push_le(32'(chans), 2);
         push_le($urandom, 4);
         push_le($urandom, 4);
         push_le($urandom, 2);
         push_le(($urandom_range(0, 19) == 0) ? $urandom : 32'(wav_pkg::BITS_PCM16), 2);
         if (fmt_len > wav_pkg::FMT_BODY)
            repeat (fmt_len - wav_pkg::FMT_BODY + fmt_len % 2)
               file_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(0, 3) == 0) push_junk_chunk();
      push_tag(wav_pkg::TAG_DATA, 2);
      case ($urandom_range(0, 19))
         0, 1: data_len = $urandom_range(0, 3);
         2: data_len = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
         default: data_len = $urandom_range(4, 40);
      endcase
      push_le(data_len, 4);
      body = (data_len > 40) ? 24 : int'(data_len) + $urandom_range(0, 3);
      repeat (body) begin
         case ($urandom_range(0, 7))
            0: octet = 8'h00;
            1: octet = 8'hFF;
            2: octet = 8'h80;
            3: octet = 8'h7F;
            default: octet = 8'($urandom);
         endcase
         file_bytes.push_back(octet);
      end
      if ($urandom_range(0, 6) == 0) begin
         cut = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endtask

   initial begin : stimulus
      logic close_file;
      int   last_idx;
      clear_parser();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < $size(DIRECTED_BYTES); i++)
         send_byte(DIRECTED_BYTES[i].sof, DIRECTED_BYTES[i].eof, DIRECTED_BYTES[i].data,
                   DIRECTED_BYTES[i].typed, DIRECTED_BYTES[i].has, DIRECTED_BYTES[i].beat);
      while (file_items < ITEM_TARGET) begin
         build_file();
         close_file = ($urandom_range(0, 9) != 0);
         last_idx = file_bytes.size() - 1;
         for (int i = 0; i <= last_idx; i++)
            send_byte(i == 0, (i == last_idx) ? close_file : ($urandom_range(0, 99) == 0),
                      file_bytes[i], 1'b0, 1'b0, NO_BEAT);
         file_items += file_bytes.size();
         // stray bytes after a file; they are still parsed as part of a file left open
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4))
               send_byte(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b0, NO_BEAT);
      end
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("wav_pcm16_stream_parser_top test passed");
      else
         $display("wav_pcm16_stream_parser_top test failed");
      $finish;
   end

   initial begin : rsp_pacing
      int mode;
      int span;
      wait (!reset);
      repeat (200) begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
      // long hold so the result register fills and the input backs up
      @(negedge clock);
      rsp_stall <= 1'b1;
      repeat (LONG_HOLD) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 7);
         span = (mode == 0) ? LONG_HOLD : $urandom_range(20, 120);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b1;
               1, 2: rsp_stall <= 1'b0;
               3: rsp_stall <= ($urandom_range(0, 9) < 8);
               default: rsp_stall <= ($urandom_range(0, 2) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("wav_pcm16_stream_parser_top test failed");
      $finish;
   end

endmodule

/* wav_pcm16_stream_parser_top.f */
hdl/wav_pkg.sv
hdl/wav_pcm16_stream_parser_top.sv
tb/wav_pcm16_stream_parser_top_tb.sv
